// File: rtl/core/rdb_pkg.sv
// Shared types and constants for the reversible deque buffer.
// Holds store geometry, action and status codes; no dependencies.
`timescale 1ns / 1ps

package rdb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;
  localparam int DATA_W      = 8;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STORE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    ACT_TOGGLE = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Physical index front + offset, wrapped once around the store.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/core/reversible_deque_buffer.sv
// Reversible byte deque: one item per cycle while the input is not stalled.
// Each item is decoded and the front pointer, fill count and reversal flag are
// updated in the accept cycle; an insert writes the byte store then, a removal
// reads it and the byte comes out of the store's read register into the output
// register when the middle stage advances. A full output register that is stalled
// holds the middle stage, and only then is the input stalled. Reversal is a
// flag toggle and moves no data. The store needs no clearing after reset.
// Depends on rdb_pkg and rdb_ram.
`timescale 1ns / 1ps

module reversible_deque_buffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic       in_at_end,
  input  logic [7:0] in_letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_letter,
  output logic       out_now_empty
);

  localparam int PTR_W = rdb_pkg::PTR_W;
  localparam int CNT_W = rdb_pkg::CNT_W;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;

  logic                      s1_valid_r, s1_valid_nxt;
  rdb_pkg::status_t          s1_status_r, s1_status_nxt;
  logic                      s1_pop_r, s1_pop_nxt;
  logic                      s1_empty_r;

  logic                      out_valid_r;
  rdb_pkg::status_t          out_status_r;
  logic [7:0]                out_letter_r;
  logic                      out_empty_r;

  logic                      accept, advance;
  logic                      we, re;
  logic [PTR_W-1:0]          waddr, raddr;
  logic [rdb_pkg::DATA_W-1:0] rdata;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    s1_status_nxt = rdb_pkg::ST_DONE;
    s1_pop_nxt    = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = front_r;
    raddr         = front_r;
    if (accept) begin
      unique case (rdb_pkg::action_t'(in_action))
        rdb_pkg::ACT_TOGGLE: begin
          rev_nxt = !rev_r;
        end
        rdb_pkg::ACT_INSERT: begin
          if (count_r >= rdb_pkg::FULL_CNT) begin
            s1_status_nxt = rdb_pkg::ST_FULL;
          end else if (in_at_end ^ rev_r) begin
            we        = 1'b1;
            waddr     = rdb_pkg::wrap_add(front_r, count_r);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            we        = 1'b1;
            front_nxt = (front_r == '0) ? rdb_pkg::LAST_PTR : front_r - PTR_W'(1);
            waddr     = front_nxt;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        rdb_pkg::ACT_REMOVE: begin
          if (count_r == '0) begin
            s1_status_nxt = rdb_pkg::ST_EMPTY;
          end else if (rev_r) begin
            re         = 1'b1;
            s1_pop_nxt = 1'b1;
            raddr      = rdb_pkg::wrap_add(front_r, count_r - CNT_W'(1));
            count_nxt  = count_r - CNT_W'(1);
          end else begin
            re         = 1'b1;
            s1_pop_nxt = 1'b1;
            raddr      = front_r;
            front_nxt  = rdb_pkg::wrap_add(front_r, CNT_W'(1));
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        default: begin
          // unused action code: leave state alone
        end
      endcase
    end
  end

  // Middle stage refills on accept, drains on advance.
  assign s1_valid_nxt = accept || (s1_valid_r && !advance);

  rdb_ram #(
    .WIDTH (rdb_pkg::DATA_W),
    .DEPTH (rdb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_letter),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      rev_r      <= rev_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_pop_r    <= s1_pop_nxt;
      s1_empty_r  <= (count_nxt == '0);
    end
    if (advance) begin
      out_status_r <= s1_status_r;
      out_letter_r <= s1_pop_r ? rdata : 8'd0;
      out_empty_r  <= s1_empty_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_letter    = out_letter_r;
  assign out_now_empty = out_empty_r;

endmodule

// File: rtl/core/rdb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; width and depth come from parameters.
`timescale 1ns / 1ps

module rdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: bench/reversible_deque_buffer_tb.sv
// Self-checking bench for the reversible byte deque: directed and random items,
// each result compared with a cycle-free model of the deque kept in the bench.
// Depends on rdb_pkg and the reversible_deque_buffer RTL.
`timescale 1ns / 1ps

module reversible_deque_buffer_tb;

  localparam int         PTR_W       = rdb_pkg::PTR_W;
  localparam int         CNT_W       = rdb_pkg::CNT_W;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         QUIET_LIMIT = 5000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TAIL_CYCLES = 8;

  typedef struct packed {
    rdb_pkg::status_t status;
    logic [7:0]       letter;
    logic             now_empty;
  } deque_result_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_action     = rdb_pkg::ACT_TOGGLE;
  logic       in_at_end     = 1'b0;
  logic [7:0] in_letter     = 8'h00;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_letter;
  logic       out_now_empty;

  // bench copy of the deque
  logic [7:0]       shadow_store [rdb_pkg::STORE_DEPTH];
  logic [PTR_W-1:0] shadow_front = '0;
  logic [CNT_W-1:0] shadow_fill  = '0;
  logic             shadow_rev   = 1'b0;

  deque_result_t awaited_results [$];
  int            fault_count = 0;
  int            quiet_cycles = 0;
  int            hold_left = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;

  reversible_deque_buffer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_at_end     (in_at_end),
    .in_letter     (in_letter),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_letter    (out_letter),
    .out_now_empty (out_now_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Physical slot at offset k past the shadow front, wrapped once.
  function automatic logic [PTR_W-1:0] shadow_slot(input int k);
    int p;
    p = int'(shadow_front) + k;
    if (p >= rdb_pkg::STORE_DEPTH) begin
      p = p - rdb_pkg::STORE_DEPTH;
    end
    return PTR_W'(p);
  endfunction

  function automatic deque_result_t deque_step(input logic [1:0] act, input logic ae,
                                               input logic [7:0] letter);
    deque_result_t r;
    r.status = rdb_pkg::ST_DONE;
    r.letter = 8'h00;
    case (act)
      rdb_pkg::ACT_TOGGLE: begin
        shadow_rev = ~shadow_rev;
      end
      rdb_pkg::ACT_INSERT: begin
        if (shadow_fill == rdb_pkg::FULL_CNT) begin
          r.status = rdb_pkg::ST_FULL;
        end else if (ae ^ shadow_rev) begin
          shadow_store[shadow_slot(int'(shadow_fill))] = letter;
          shadow_fill = shadow_fill + CNT_W'(1);
        end else begin
          shadow_front = (shadow_front == '0) ? rdb_pkg::LAST_PTR
                                              : shadow_front - PTR_W'(1);
          shadow_store[shadow_front] = letter;
          shadow_fill = shadow_fill + CNT_W'(1);
        end
      end
      rdb_pkg::ACT_REMOVE: begin
        if (shadow_fill == '0) begin
          r.status = rdb_pkg::ST_EMPTY;
        end else if (shadow_rev) begin
          r.letter = shadow_store[shadow_slot(int'(shadow_fill) - 1)];
          shadow_fill = shadow_fill - CNT_W'(1);
        end else begin
          r.letter = shadow_store[shadow_front];
          shadow_front = shadow_slot(1);
          shadow_fill = shadow_fill - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    r.now_empty = (shadow_fill == '0);
    return r;
  endfunction

  // Offer one item, idling first at random; predict once it is taken.
  task automatic send_item(input logic [1:0] act, input logic ae, input logic [7:0] letter);
    while (!tx_calm && $urandom_range(0, 99) < 30) begin
      in_valid  <= 1'b0;
      in_action <= 2'($urandom);
      in_at_end <= 1'($urandom);
      in_letter <= 8'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_at_end <= ae;
    in_letter <= letter;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    awaited_results = {awaited_results, deque_step(act, ae, letter)};
  endtask

  task automatic send_random(input int ins_pct, input int rem_pct);
    int         roll;
    logic [1:0] act;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      act = ACT_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      act = rdb_pkg::ACT_INSERT;
    end else if (roll < 3 + ins_pct + rem_pct) begin
      act = rdb_pkg::ACT_REMOVE;
    end else begin
      act = rdb_pkg::ACT_TOGGLE;
    end
    send_item(act, 1'($urandom), 8'($urandom));
  endtask

  // Hold the sender until every awaited result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'hFF);
    send_item(rdb_pkg::ACT_TOGGLE, 1'b1, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b1, 8'h00);
    send_item(rdb_pkg::ACT_TOGGLE, 1'b0, 8'h5A);
    send_item(rdb_pkg::ACT_INSERT, 1'b1, 8'h00);
    send_item(rdb_pkg::ACT_INSERT, 1'b1, 8'hFF);
    // front push from slot zero wraps to the top of the store
    send_item(rdb_pkg::ACT_INSERT, 1'b0, 8'hA5);
    send_item(rdb_pkg::ACT_INSERT, 1'b0, 8'h01);
    send_item(ACT_UNUSED, 1'b1, 8'hFF);
    send_item(rdb_pkg::ACT_TOGGLE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_INSERT, 1'b0, 8'h80);
    send_item(rdb_pkg::ACT_INSERT, 1'b1, 8'h7F);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b1, 8'h00);
    send_item(rdb_pkg::ACT_TOGGLE, 1'b1, 8'hFF);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b0, 8'h00);
    send_item(ACT_UNUSED, 1'b0, 8'h00);
    send_item(rdb_pkg::ACT_REMOVE, 1'b1, 8'hFF);
    drain_results();
  endtask

  // Stall the result side for a long stretch while items keep coming.
  task automatic test_backpressure();
    tx_calm   = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (60) send_random(55, 35);
    tx_calm = 1'b0;
    drain_results();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 300; n++) begin
      send_random(45, 45);
      if (n % 64 == 63) begin
        drain_results();
      end
    end
    drain_results();
  endtask

  task automatic test_fill_to_full();
    int n;
    n = 0;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    while (shadow_fill != rdb_pkg::FULL_CNT) begin
      send_random(90, 4);
      n++;
      if (n == 400) begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    // every insert from here on is dropped
    repeat (12) send_item(rdb_pkg::ACT_INSERT, 1'($urandom), 8'($urandom));
    send_item(rdb_pkg::ACT_TOGGLE, 1'($urandom), 8'($urandom));
    repeat (4) send_item(rdb_pkg::ACT_INSERT, 1'($urandom), 8'($urandom));
    drain_results();
  endtask

  task automatic test_partial_drain();
    repeat (450) send_random(25, 65);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_mix();
    test_fill_to_full();
    test_partial_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("reversible_deque_buffer_tb: clean");
    end else begin
      $display("reversible_deque_buffer_tb: errors");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("%0t: result with none awaited: status %0d letter %02h empty %0b",
                   $realtime, out_status, out_letter, out_now_empty);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_letter !== want.letter ||
            out_now_empty !== want.now_empty) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: mismatch: want status %0d letter %02h empty %0b, got %0d %02h %0b",
                     $realtime, want.status, want.letter, want.now_empty,
                     out_status, out_letter, out_now_empty);
          end
        end
      end
    end
  end

  // Abort when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("reversible_deque_buffer_tb: errors");
        $finish;
      end
    end
  end

endmodule

// File: files.f
rtl/core/rdb_pkg.sv
rtl/core/rdb_ram.sv
rtl/core/reversible_deque_buffer.sv
bench/reversible_deque_buffer_tb.sv
